// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define WSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication: the consequent must hold in the cycle of the antecedent.
`define WSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define WSM_ASSERT(label, clk, rst_n, prop, msg)
`define WSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/wsm_pkg.sv =====
// Package: sizes, command codes and status codes of the wildcard matcher.
`timescale 1ns / 1ps
package wsm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int PAT_AW      = $clog2(PATTERN_MAX);
  localparam int PAT_LW      = $clog2(PATTERN_MAX + 1);

  // Input commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SUBJ   = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  // Result status
  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_TAIL     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_MANY = 1'b0;
  localparam logic REG_ONE  = 1'b1;

endpackage

// ===== rtl/core/wildcard_string_matcher.sv =====
// Top level: streaming wildcard matcher with pattern store and step sequencer.
//
// Input channel (in_valid_i / in_stall_o) takes command and char_value beats:
// clear pattern, append pattern byte, subject byte, end of subject. Output
// channel (out_valid_o / out_stall_i) carries one match_status beat for each
// end-of-subject command. The APB port sets the many-wildcard (addr 0) and
// one-wildcard (addr 4) codes; pready is always high.
// Clear and append are handled in the idle state. A subject byte then takes
// one step per pattern byte visited: forward over a run of wildcards, then the
// walk back toward the last many-wildcard. An end of subject answers from the
// idle state or first scans the remaining pattern bytes. Each step is one read
// of the single-port pattern memory and one byte compare, so the memory read
// sets the pace.
// The status is held in an output register; the next beat is taken while it
// waits, unless the receiver stalls with the register full.
// Reset clears the pattern length, matching state and overflow flag and
// restores the wildcard codes to 42 and 63; the store itself is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wildcard_string_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  char_value_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  match_status_o
);
  import wsm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FWD  = 2'd1;
  localparam logic [1:0] S_BACK = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [7:0]        many_q, one_q;
  logic [PAT_LW-1:0] len_q, len_d;
  logic [PAT_LW-1:0] pidx_q, pidx_d;
  logic [PAT_AW-1:0] star_q, star_d;
  logic              seen_q, seen_d;
  logic              failed_q, failed_d;
  logic              slo_q, slo_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        cs_q, cs_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;

  logic [7:0]        mem [PATTERN_MAX];
  logic [7:0]        rdata_q;
  logic [PAT_AW-1:0] raddr;
  logic              we;

  logic              accept, out_free, emit, restart;
  logic [1:0]        emit_status;
  logic [PAT_LW-1:0] pidx_inc, pidx_dec;
  logic              inc_in_range, dec_above_star;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {24'd0, (paddr[2] == REG_ONE) ? one_q : many_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      many_q <= 8'd42;
      one_q  <= 8'd63;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ONE) begin
        one_q <= pwdata[7:0];
      end else begin
        many_q <= pwdata[7:0];
      end
    end
  end

  // handshake
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign match_status_o = status_q;

  assign pidx_inc       = pidx_q + PAT_LW'(1);
  assign pidx_dec       = pidx_q - PAT_LW'(1);
  assign inc_in_range   = pidx_inc < len_q;
  assign dec_above_star = pidx_dec > {1'b0, star_q};

  // sequencer: one memory read and one compare per cycle
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pidx_d      = pidx_q;
    star_d      = star_q;
    seen_d      = seen_q;
    failed_d    = failed_q;
    slo_d       = slo_q;
    ovf_d       = ovf_q;
    cs_d        = cs_q;
    raddr       = pidx_q[PAT_AW-1:0];
    we          = 1'b0;
    emit        = 1'b0;
    emit_status = ST_MATCH;
    restart     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_CLEAR: begin
              len_d   = '0;
              ovf_d   = 1'b0;
              restart = 1'b1;
            end
            CMD_APPEND: begin
              if (len_q < PAT_LW'(PATTERN_MAX)) begin
                we    = 1'b1;
                len_d = len_q + PAT_LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_SUBJ: begin
              if (!failed_q) begin
                if (pidx_q < len_q) begin
                  cs_d    = char_value_i;
                  state_d = S_FWD;
                end else begin
                  slo_d = 1'b1;
                end
              end
            end
            default: begin
              // end of subject
              if (ovf_q) begin
                emit = 1'b1;
                emit_status = ST_OVERFLOW;
              end else if (failed_q) begin
                emit = 1'b1;
                emit_status = ST_MISMATCH;
              end else if (pidx_q >= len_q) begin
                if (!slo_q || len_q == '0) begin
                  emit = 1'b1;
                  emit_status = ST_MATCH;
                end else begin
                  // subject ran past the pattern: check its last byte
                  pidx_d  = len_q - PAT_LW'(1);
                  raddr   = pidx_d[PAT_AW-1:0];
                  state_d = S_TAIL;
                end
              end else begin
                state_d = S_TAIL;
              end
              if (emit) begin
                restart = 1'b1;
              end
            end
          endcase
        end
      end
      S_FWD: begin
        if (rdata_q == cs_q) begin
          pidx_d  = pidx_inc;
          state_d = S_IDLE;
        end else if (rdata_q == many_q) begin
          star_d = pidx_q[PAT_AW-1:0];
          seen_d = 1'b1;
          pidx_d = pidx_inc;
          if (inc_in_range) begin
            raddr = pidx_inc[PAT_AW-1:0];
          end else begin
            slo_d   = 1'b1;
            state_d = S_IDLE;
          end
        end else if (rdata_q == one_q) begin
          pidx_d  = pidx_inc;
          state_d = S_IDLE;
        end else if (seen_q) begin
          // current byte already known not to match: step back once
          if (pidx_q > {1'b0, star_q}) begin
            pidx_d = pidx_dec;
            if (dec_above_star) begin
              raddr   = pidx_dec[PAT_AW-1:0];
              state_d = S_BACK;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            // already sitting on the star index: nothing to walk
            state_d = S_IDLE;
          end
        end else begin
          failed_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_BACK: begin
        // literal walk back toward the last many-wildcard
        if (rdata_q == cs_q) begin
          pidx_d  = pidx_inc;
          state_d = S_IDLE;
        end else begin
          pidx_d = pidx_dec;
          if (dec_above_star) begin
            raddr = pidx_dec[PAT_AW-1:0];
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        // S_TAIL: remaining pattern must be all many-wildcards
        if (rdata_q != many_q) begin
          if (out_free) begin
            emit = 1'b1;
            emit_status = ST_TAIL;
          end
        end else if (inc_in_range) begin
          pidx_d = pidx_inc;
          raddr  = pidx_inc[PAT_AW-1:0];
        end else if (out_free) begin
          emit = 1'b1;
          emit_status = ST_MATCH;
        end
        if (emit) begin
          restart = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase

    if (restart) begin
      pidx_d   = '0;
      star_d   = '0;
      seen_d   = 1'b0;
      failed_d = 1'b0;
      slo_d    = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    if (emit) begin
      out_valid_d = 1'b1;
      status_d    = emit_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      pidx_q      <= '0;
      star_q      <= '0;
      seen_q      <= 1'b0;
      failed_q    <= 1'b0;
      slo_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pidx_q      <= pidx_d;
      star_q      <= star_d;
      seen_q      <= seen_d;
      failed_q    <= failed_d;
      slo_q       <= slo_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cs_q     <= cs_d;
    status_q <= status_d;
  end

  // pattern memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[len_q[PAT_AW-1:0]] <= char_value_i;
    end
    rdata_q <= mem[raddr];
  end

  // checks
  `WSM_ASSERT(a_pidx_in_len, clk_i, rst_ni, pidx_q <= len_q, "pattern index past length")
  `WSM_ASSERT_IMP(a_star_below, clk_i, rst_ni, seen_q, PAT_LW'(star_q) <= pidx_q,
    "star index above pattern index")
  `WSM_ASSERT_IMP(a_back_above_star, clk_i, rst_ni, state_q == S_BACK,
    pidx_q > PAT_LW'(star_q), "walk back reached star index")
  `WSM_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, state_q == S_FWD || state_q == S_TAIL,
    pidx_q < len_q, "scan index outside pattern")

endmodule

// ===== bench/wildcard_string_matcher_test.sv =====
// Testbench for the streaming wildcard matcher: random beats, status prediction, checks.
`timescale 1ns / 1ps
module wildcard_string_matcher_test;
  import wsm_pkg::*;

  localparam logic [7:0] DEFAULT_MANY = 8'd42;
  localparam logic [7:0] DEFAULT_ONE  = 8'd63;
  localparam int BEATS_PER_PHASE = 300;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 2 * PATTERN_MAX + 8;
  localparam int WATCHDOG_LIMIT  = 5000;

  // Status predictor and queue of statuses still owed by the block
  class match_status_board;
    logic [7:0]        many_code;
    logic [7:0]        one_code;
    logic [7:0]        pat_mem [PATTERN_MAX];
    logic [PAT_LW-1:0] pat_len;
    logic [PAT_LW-1:0] pat_idx;
    logic [PAT_AW-1:0] star_idx;
    bit                star_seen;
    bit                failed;
    bit                left_over;
    bit                overflow;
    logic [1:0]        status_due [$];
    int                fail_count;

    function new();
      many_code  = DEFAULT_MANY;
      one_code   = DEFAULT_ONE;
      pat_len    = '0;
      overflow   = 1'b0;
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      pat_idx   = '0;
      star_idx  = '0;
      star_seen = 1'b0;
      failed    = 1'b0;
      left_over = 1'b0;
    endfunction

    function void set_code(logic idx, logic [7:0] val);
      if (idx == REG_MANY) many_code = val;
      else one_code = val;
    endfunction

    function logic [7:0] pat_at(logic [PAT_LW-1:0] i);
      return (i < pat_len) ? pat_mem[i] : 8'h00;
    endfunction

    // One subject byte: forward over wildcards, walk back after a star on mismatch
    function void take_subject(logic [7:0] cs);
      logic [7:0] ce;
      if (failed) return;
      while (pat_idx < pat_len) begin
        ce = pat_at(pat_idx);
        if (ce == cs) begin
          pat_idx++;
          return;
        end
        if (ce == many_code) begin
          star_idx  = pat_idx[PAT_AW-1:0];
          star_seen = 1'b1;
          pat_idx++;
          continue;
        end
        if (ce == one_code) begin
          pat_idx++;
          return;
        end
        if (star_seen) begin
          while (pat_idx > star_idx) begin
            if (pat_at(pat_idx) == cs) break;
            pat_idx--;
          end
          if (pat_idx > star_idx) pat_idx++;
          return;
        end
        failed = 1'b1;
        return;
      end
      left_over = 1'b1;
    endfunction

    function logic [1:0] predict_end_status();
      logic [PAT_LW-1:0] i;
      if (overflow) return ST_OVERFLOW;
      if (failed) return ST_MISMATCH;
      if (!left_over && pat_idx >= pat_len) return ST_MATCH;
      i = pat_idx;
      if (i >= pat_len) begin
        if (pat_len == 0) return ST_MATCH;
        i = pat_len - 1'b1;
      end
      while (i < pat_len) begin
        if (pat_at(i) != many_code) return ST_TAIL;
        i++;
      end
      return ST_MATCH;
    endfunction

    // Accepted input beat
    function void note_beat(logic [1:0] cmd, logic [7:0] ch);
      case (cmd)
        CMD_CLEAR: begin
          pat_len  = '0;
          overflow = 1'b0;
          restart();
        end
        CMD_APPEND: begin
          if (pat_len < PATTERN_MAX) begin
            pat_mem[pat_len] = ch;
            pat_len++;
          end else begin
            overflow = 1'b1;
          end
        end
        CMD_SUBJ: take_subject(ch);
        default: begin
          status_due.push_back(predict_end_status());
          restart();
        end
      endcase
    endfunction

    // Accepted result beat
    function void check_status(logic [1:0] got);
      logic [1:0] want;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected status: expected none, actual %0d", $time, got);
        fail_count++;
        return;
      end
      want = status_due.pop_front();
      if (got !== want) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want, got);
        fail_count++;
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [7:0]  char_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  match_status;

  match_status_board sb;
  int         beats_sent;
  int         run_left;
  int         idle_cycles;
  bit         burst_mode;
  bit         hold_off_req;
  logic [7:0] pat_shadow [$];
  logic [7:0] subj_buf [$];

  wildcard_string_matcher i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .char_value_i   (char_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .match_status_o (match_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Gap length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Subject-side byte: small alphabet, wildcard codes, any byte
  function automatic logic [7:0] literal_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'("a") + 8'($urandom_range(0, 2));
    if (r < 80) return sb.many_code;
    if (r < 88) return sb.one_code;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return sb.many_code;
    if (r < 32) return sb.one_code;
    return literal_byte();
  endfunction

  // Result side: random stall runs, plus one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_stall = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
      out_stall = 1'b0;
      run_left = 0;
    end else if (run_left > 0) begin
      run_left--;
    end else if (burst_mode) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(0, 2) == 0);
      run_left  = out_stall ? idle_len() : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_status(match_status);
  end

  // Watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one beat from a falling edge, return at the falling edge after acceptance
  task automatic send_beat(logic [1:0] cmd, logic [7:0] ch);
    int gap;
    gap = burst_mode ? 0 : idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    command    = cmd;
    char_value = ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(cmd, ch);
    beats_sent++;
    @(negedge clk);
  endtask

  // Register write, then read back
  task automatic apb_access(logic idx, logic [7:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_code(idx, val);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== val) begin
      $display("%0t: register %0d readback: expected %0d, actual %0d",
               $time, idx, val, prdata[7:0]);
      sb.fail_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Let the block go quiet: all statuses back, then time for a trailing walk
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Subject that mostly fits the loaded pattern, sometimes broken
  task automatic build_subject();
    int r;
    subj_buf.delete();
    foreach (pat_shadow[k]) begin
      if (pat_shadow[k] == sb.many_code) repeat ($urandom_range(0, 3))
        subj_buf.push_back(literal_byte());
      else if (pat_shadow[k] == sb.one_code) subj_buf.push_back(literal_byte());
      else subj_buf.push_back(pat_shadow[k]);
    end
    r = $urandom_range(0, 99);
    if (r < 20 && subj_buf.size() > 0)
      subj_buf[$urandom_range(0, subj_buf.size() - 1)] = literal_byte();
    else if (r < 30) subj_buf.push_back(literal_byte());
    else if (r < 38 && subj_buf.size() > 0) void'(subj_buf.pop_back());
  endtask

  // Pattern load followed by a few subjects, or a burst of noise
  task automatic run_sequence();
    int r;
    int plen;
    int nsub;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(5, 15))
        send_beat(2'($urandom_range(CMD_CLEAR, CMD_END)), 8'($urandom_range(0, 255)));
      return;
    end
    if (r < 92 || pat_shadow.size() > PATTERN_MAX) begin
      send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
      pat_shadow.delete();
    end
    r = $urandom_range(0, 99);
    if (r < 80) plen = $urandom_range(0, 10);
    else if (r < 92) plen = $urandom_range(11, 40);
    else plen = $urandom_range(PATTERN_MAX - 8, PATTERN_MAX + 6);
    repeat (plen) begin
      c = pattern_byte();
      pat_shadow.push_back(c);
      send_beat(CMD_APPEND, c);
    end
    nsub = (plen > 40) ? $urandom_range(1, 2) : $urandom_range(1, 4);
    repeat (nsub) begin
      build_subject();
      foreach (subj_buf[k]) begin
        // occasional append in the middle of a subject
        if ($urandom_range(0, 99) < 2) begin
          c = pattern_byte();
          pat_shadow.push_back(c);
          send_beat(CMD_APPEND, c);
        end
        send_beat(CMD_SUBJ, subj_buf[k]);
      end
      send_beat(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target;
    logic [7:0] m;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    command = CMD_CLEAR;
    char_value = 8'h00;
    out_stall = 1'b0;
    beats_sent = 0;
    run_left = 0;
    idle_cycles = 0;
    burst_mode = 1'b0;
    hold_off_req = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty pattern matches anything
    send_beat(CMD_END, 8'hFF);
    // zero byte, star, all-ones byte; star skips and walks back
    send_beat(CMD_APPEND, 8'h00);
    send_beat(CMD_APPEND, DEFAULT_MANY);
    send_beat(CMD_APPEND, 8'hFF);
    send_beat(CMD_SUBJ, 8'h00);
    send_beat(CMD_SUBJ, "x");
    send_beat(CMD_SUBJ, "y");
    send_beat(CMD_SUBJ, 8'hFF);
    send_beat(CMD_END, 8'h00);
    // star code taken literally, then a hard mismatch and an ignored byte
    send_beat(CMD_SUBJ, 8'h00);
    send_beat(CMD_SUBJ, DEFAULT_MANY);
    send_beat(CMD_SUBJ, "z");
    send_beat(CMD_SUBJ, 8'hFF);
    send_beat(CMD_END, 8'h00);
    // subject longer than the pattern
    send_beat(CMD_SUBJ, 8'h00);
    send_beat(CMD_SUBJ, 8'hFF);
    send_beat(CMD_SUBJ, "q");
    send_beat(CMD_END, 8'h00);
    // unmatched tail, then one-wildcard match with star tail
    send_beat(CMD_CLEAR, 8'h55);
    send_beat(CMD_APPEND, "a");
    send_beat(CMD_APPEND, DEFAULT_ONE);
    send_beat(CMD_APPEND, DEFAULT_MANY);
    send_beat(CMD_SUBJ, "a");
    send_beat(CMD_END, 8'hAA);
    send_beat(CMD_SUBJ, "a");
    send_beat(CMD_SUBJ, "b");
    send_beat(CMD_END, 8'h00);
    pat_shadow = '{"a", DEFAULT_ONE, DEFAULT_MANY};

    // Random phases; from the second on, the wildcard codes are set anew before each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_quiet();
        case (ph)
          1: begin apb_access(REG_MANY, 8'h00); apb_access(REG_ONE, 8'hFF); end
          2: begin apb_access(REG_MANY, 8'hFF); apb_access(REG_ONE, 8'h00); end
          3: begin
            apb_access(REG_MANY, 8'($urandom_range(0, 255)));
            apb_access(REG_ONE, 8'($urandom_range(0, 255)));
          end
          4: begin
            m = 8'($urandom_range(0, 255));
            apb_access(REG_MANY, m);
            apb_access(REG_ONE, m);
          end
          default: begin
            apb_access(REG_MANY, DEFAULT_MANY);
            apb_access(REG_ONE, DEFAULT_ONE);
          end
        endcase
        pat_shadow.delete();
      end
      burst_mode = (ph == 3);
      if (ph == 2) hold_off_req = 1'b1;
      target = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < target) run_sequence();
    end

    in_valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
